### src/savitzky_golay_smoothing_macros.svh
// Assertion macros for the Savitzky-Golay smoother.
// Used by the top level only; no other dependencies.
`ifndef SAVITZKY_GOLAY_SMOOTHING_MACROS_SVH
`define SAVITZKY_GOLAY_SMOOTHING_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SGS_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define SGS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/sgs_pkg.sv
// Shared types, widths and tap constants for the Savitzky-Golay smoother.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sgs_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int TAP_COUNT   = 7;
   localparam int TAP_BITS    = 4;
   // |tap * sample| < 2^(SAMPLE_BITS+2)
   localparam int TERM_BITS   = SAMPLE_BITS + 3;
   // |sum of taps| <= 29 * 2^(SAMPLE_BITS-1)
   localparam int ACC_BITS    = SAMPLE_BITS + 5;
   localparam int MAG_BITS    = SAMPLE_BITS + 4;
   // 3 * magnitude, divided by 63 (= 2^6 - 1)
   localparam int TRIPLE_BITS = SAMPLE_BITS + 6;
   localparam int FOLD_SHIFT  = 6;
   localparam int FOLD_BASE   = 63;
   localparam int FOLD_TERMS  = (TRIPLE_BITS + FOLD_SHIFT - 1) / FOLD_SHIFT;
   localparam int REM_BITS    = $clog2(FOLD_BASE * (FOLD_TERMS + 1));
   localparam int CORR_BITS   = $clog2(FOLD_TERMS + 1);
   localparam int QUOT_BITS   = SAMPLE_BITS;

   localparam int POS_BITS    = 3;
   localparam logic [POS_BITS-1:0] POS_MAX  = 3'd7;
   localparam logic [POS_BITS-1:0] EMIT_POS = 3'd3;

   localparam int FLUSH_BITS  = 2;
   localparam logic [FLUSH_BITS-1:0] FLUSH_SHIFTS = 2'd3;
   localparam logic [FLUSH_BITS-1:0] FLUSH_LAST   = 2'd1;

   typedef logic signed [TAP_BITS-1:0]    tap_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [TERM_BITS-1:0]   term_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   localparam tap_type SG_TAPS [TAP_COUNT] =
      '{-4'sd2, 4'sd3, 4'sd6, 4'sd7, 4'sd6, 4'sd3, -4'sd2};

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      sample_type sample;
      logic       frame_end;
   } sgs_req_type;

   typedef struct packed {
      sample_type smoothed;
      logic       frame_last;
   } sgs_rsp_type;

   // Per-stage beat tag
   typedef struct packed {
      logic valid;
      logic last;
   } sgs_tag_type;

endpackage

### src/savitzky_golay_smoothing.sv
// Seven-point quadratic Savitzky-Golay smoother, frame based, valid/ready on both sides.
// Channels: req_ beats carry one signed sample and a frame-end flag; rsp_ beats carry one
//   smoothed sample and a flag on the last output of the frame.
// Output k of a frame leaves once sample k+3 has been taken; the frame-end beat then
//   flushes the remaining outputs (up to four in all) by shifting zeros into the window.
// Throughput: one beat per cycle in each direction while the pipe is not held. After a
//   frame-end beat, req_ready drops while the flush zeros pass through the cell row.
// Path: a result reaches rsp_valid through the cell row, tap adder, four divide-by-21
//   stages and the output register.
// Stall: the output register plus a one-entry skid buffer part the two sides; when the
//   skid fills, the whole pipe holds and req_ready drops until the receiver takes a beat.
// Reset: synchronous, active high; clears frame position, flush count and all valid
//   flags. The window needs no reset: the first sample of a frame zeroes older cells.
// Depends on sgs_pkg, sgs_cell, sgs_div21 and the assertion macro header.
`timescale 1ns / 1ps
`include "savitzky_golay_smoothing_macros.svh"

module savitzky_golay_smoothing
   import sgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sgs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sgs_rsp_type rsp_data
);

   // pipe control
   logic                  advance;
   logic                  flushing;
   logic                  flush_final;
   logic                  req_fire;
   logic                  shift;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [FLUSH_BITS-1:0] flush_cnt_ff, flush_cnt_in;

   // cell row (stage A)
   sample_type            head_sample;
   logic                  first_of_frame;
   sample_type            sample_w [TAP_COUNT];
   term_type              term_w   [TAP_COUNT];
   sgs_tag_type           tag_a_ff, tag_a_in;

   // tap adder (stage B)
   acc_type               acc_ff, acc_in;
   sgs_tag_type           tag_b_ff;

   // divider output
   sgs_tag_type           tag_div;
   sample_type            div_result;

   // output register and skid
   sgs_rsp_type           main_ff, main_in, skid_ff, skid_in, beat_in;
   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic                  beat_valid;
   logic                  pop;

   // ---------------------------------------------------------------- control
   assign advance     = !skid_valid_ff;
   assign flushing    = (flush_cnt_ff != '0);
   assign flush_final = flushing && (flush_cnt_ff == FLUSH_LAST);
   assign req_ready   = advance && !flushing;
   assign req_fire    = req_valid && req_ready;
   assign shift       = req_fire || (advance && flushing);

   always_comb begin
      pos_in = pos_ff;
      if (shift) begin
         if (flush_final) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      flush_cnt_in = flush_cnt_ff;
      if (req_fire && req_data.frame_end) begin
         flush_cnt_in = FLUSH_SHIFTS;
      end else if (flushing && advance) begin
         flush_cnt_in = flush_cnt_ff - 1'b1;
      end
   end

   // every shift with three or more samples behind it yields the centre cell's output
   always_comb begin
      tag_a_in = tag_a_ff;
      if (advance) begin
         tag_a_in.valid = shift && (pos_ff >= EMIT_POS);
         tag_a_in.last  = shift && flush_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         flush_cnt_ff <= '0;
         tag_a_ff     <= '0;
         tag_b_ff     <= '0;
      end else begin
         pos_ff       <= pos_in;
         flush_cnt_ff <= flush_cnt_in;
         tag_a_ff     <= tag_a_in;
         if (advance) begin
            tag_b_ff <= tag_a_ff;
         end
      end
   end

   // ---------------------------------------------------------------- cell row
   assign head_sample    = flushing ? '0 : req_data.sample;
   assign first_of_frame = (pos_ff == '0);

   for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
      if (i == 0) begin : g_head
         sgs_cell u_cell (
            .clock       (clock),
            .shift       (shift),
            .clear       (1'b0),
            .tap         (SG_TAPS[i]),
            .sample_prev (head_sample),
            .sample_out  (sample_w[i]),
            .term_out    (term_w[i])
         );
      end else begin : g_body
         sgs_cell u_cell (
            .clock       (clock),
            .shift       (shift),
            .clear       (first_of_frame),
            .tap         (SG_TAPS[i]),
            .sample_prev (sample_w[i-1]),
            .sample_out  (sample_w[i]),
            .term_out    (term_w[i])
         );
      end
   end

   // ---------------------------------------------------------------- tap adder
   always_comb begin
      acc_in = '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
         acc_in = acc_in + ACC_BITS'(term_w[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------- divide, saturate
   sgs_div21 u_div21 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tag_in  (tag_b_ff),
      .acc_in  (acc_ff),
      .tag_out (tag_div),
      .result  (div_result)
   );

   // ---------------------------------------------------------------- output + skid
   assign beat_valid         = advance && tag_div.valid;
   assign beat_in.smoothed   = div_result;
   assign beat_in.frame_last = tag_div.last;
   assign pop                = main_valid_ff && rsp_ready;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (beat_valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = beat_in;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = beat_in;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end else begin
         // nothing arrives, nothing leaves
         main_valid_in = main_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // ---------------------------------------------------------------- assertions
   `SGS_ASSERT_HOLDS(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff,
      "skid holds a beat while the output register is empty")
   `SGS_ASSERT_HOLDS(a_last_is_emitted, clock, reset, tag_a_ff.last, tag_a_ff.valid,
      "final flush shift produced no output")
   `SGS_ASSERT_HOLDS(a_no_flush_at_start, clock, reset, pos_ff == '0, flush_cnt_ff == '0,
      "flush running with an empty frame")
   `SGS_ASSERT_NEXT(a_frame_end_blocks, clock, reset, req_fire && req_data.frame_end,
      !req_ready, "input taken straight after a frame end")

endmodule

### src/sgs_cell.sv
// One window cell: holds a sample and its tap-weighted copy, shifts to the next cell.
// Depends on sgs_pkg.
`timescale 1ns / 1ps

module sgs_cell
   import sgs_pkg::*;
(
   input  logic       clock,
   input  logic       shift,
   input  logic       clear,
   input  tap_type    tap,
   input  sample_type sample_prev,
   output sample_type sample_out,
   output term_type   term_out
);

   sample_type sample_ff, sample_in;
   term_type   term_ff, term_in;

   always_comb begin
      sample_in = clear ? '0 : sample_prev;
      term_in   = TERM_BITS'(tap) * TERM_BITS'(sample_in);
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         sample_ff <= sample_in;
         term_ff   <= term_in;
      end
   end

   assign sample_out = sample_ff;
   assign term_out   = term_ff;

endmodule

### src/sgs_div21.sv
// Pipelined signed divide by 21 (truncating) with saturation to sample width.
// x/21 = 3x/63; 3x/63 folded by 6-bit shifts then corrected. Depends on sgs_pkg.
`timescale 1ns / 1ps

module sgs_div21
   import sgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  sgs_tag_type tag_in,
   input  acc_type     acc_in,
   output sgs_tag_type tag_out,
   output sample_type  result
);

   // stage C: magnitude times three
   sgs_tag_type                  tag_c_ff;
   logic                         neg_c_ff;
   logic [TRIPLE_BITS-1:0]       triple_c_ff, triple_in;
   logic [MAG_BITS-1:0]          mag;
   // stage D: folded quotient estimate
   sgs_tag_type                  tag_d_ff;
   logic                         neg_d_ff;
   logic [REM_BITS-1:0]          triple_d_ff;
   logic [QUOT_BITS-1:0]         fold_d_ff, fold_in;
   // stage E: remainder of estimate
   sgs_tag_type                  tag_e_ff;
   logic                         neg_e_ff;
   logic [REM_BITS-1:0]          rem_e_ff, rem_in;
   logic [QUOT_BITS-1:0]         fold_e_ff;
   // stage F: corrected quotient
   sgs_tag_type                  tag_f_ff;
   logic                         neg_f_ff;
   logic [QUOT_BITS-1:0]         quot_f_ff, quot_in;
   logic [CORR_BITS-1:0]         corr_in;

   always_comb begin
      mag       = acc_in[ACC_BITS-1] ? MAG_BITS'(-acc_in) : MAG_BITS'(acc_in);
      triple_in = TRIPLE_BITS'(mag) + (TRIPLE_BITS'(mag) << 1);
   end

   // sum of t >> 6k underestimates t/63 by less than FOLD_TERMS
   always_comb begin
      fold_in = '0;
      for (int k = 1; k <= FOLD_TERMS; k++) begin
         fold_in = fold_in + QUOT_BITS'(triple_c_ff >> (FOLD_SHIFT * k));
      end
   end

   // true remainder is small, so low bits are enough
   assign rem_in = triple_d_ff - REM_BITS'({fold_d_ff, {FOLD_SHIFT{1'b0}}})
                   + REM_BITS'(fold_d_ff);

   always_comb begin
      corr_in = '0;
      for (int j = 1; j <= FOLD_TERMS; j++) begin
         if (rem_e_ff >= REM_BITS'(FOLD_BASE * j)) begin
            corr_in = corr_in + 1'b1;
         end
      end
      quot_in = fold_e_ff + QUOT_BITS'(corr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_c_ff <= '0;
         tag_d_ff <= '0;
         tag_e_ff <= '0;
         tag_f_ff <= '0;
      end else if (advance) begin
         tag_c_ff <= tag_in;
         tag_d_ff <= tag_c_ff;
         tag_e_ff <= tag_d_ff;
         tag_f_ff <= tag_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_c_ff    <= acc_in[ACC_BITS-1];
         triple_c_ff <= triple_in;
         neg_d_ff    <= neg_c_ff;
         triple_d_ff <= REM_BITS'(triple_c_ff);
         fold_d_ff   <= fold_in;
         neg_e_ff    <= neg_d_ff;
         rem_e_ff    <= rem_in;
         fold_e_ff   <= fold_d_ff;
         neg_f_ff    <= neg_e_ff;
         quot_f_ff   <= quot_in;
      end
   end

   // saturate: a quotient of 2^(N-1) or more gives the limit of its sign
   always_comb begin
      if (quot_f_ff[QUOT_BITS-1]) begin
         result = neg_f_ff ? SAMPLE_MIN : SAMPLE_MAX;
      end else if (neg_f_ff) begin
         result = -$signed(quot_f_ff);
      end else begin
         result = $signed(quot_f_ff);
      end
   end

   assign tag_out = tag_f_ff;

endmodule

### verif/testbench.sv
// Self-checking bench for the seven-point Savitzky-Golay smoother.
// Holds its own frame-window predictor, a directed table and random frames.
// Depends on sgs_pkg and the savitzky_golay_smoothing top level.
`timescale 1ns / 1ps

module testbench;
   import sgs_pkg::*;

   // One row of the directed table: the beat to send and, where the
   // answer is obvious by hand, the single result it must release.
   typedef struct {
      sgs_req_type beat;
      bit          typed;
      sgs_rsp_type want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_BEATS  = 95;
   localparam int CALM_BEATS    = 25;  // last beats run with no idling
   localparam int LONG_HOLD     = 80;  // receiver hold-off, cycles
   localparam int HOLD_AFTER    = 50;  // results seen before the hold-off
   localparam int PAUSE_AT      = 40;  // random beats left at the mid-run pause
   localparam int TAIL_CYCLES   = 20;  // idle wait after all results are in, with margin

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   sgs_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   sgs_rsp_type rsp_data;

   savitzky_golay_smoothing dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor state: the six newest samples of the open frame (oldest at
   // index 0) and how many samples of the frame have gone by, saturating.
   // ---------------------------------------------------------------------
   sample_type        frame_win [6];
   logic [2:0]        frame_pos;
   longint            taps_in [10];   // window, new sample, three zero pads
   sgs_rsp_type       smoothed_due [$];

   int  errors;
   int  beats_in;
   int  beats_out;
   int  frames_in;
   int  long_frames;
   int  short_frames;
   int  saturated;
   bit  calm;
   bit  long_hold_done;

   sgs_rsp_type  due_head;
   stim_row_type directed_rows [DIRECTED_ROWS];

   // Weighted sum about centre c of taps_in, /21 toward zero, clamped.
   function automatic sample_type sg_point(input int c);
      longint acc;
      acc = 0;
      for (int t = 0; t < TAP_COUNT; t++)
         acc += longint'(SG_TAPS[t]) * taps_in[c - 3 + t];
      acc = acc / 21;
      if (acc > longint'(SAMPLE_MAX)) begin
         acc = longint'(SAMPLE_MAX);
         saturated++;
      end else if (acc < longint'(SAMPLE_MIN)) begin
         acc = longint'(SAMPLE_MIN);
         saturated++;
      end
      return sample_type'(acc);
   endfunction

   // Work out every result an accepted beat releases and queue it.
   task automatic sg_predict(input sgs_req_type d);
      int first_c;
      for (int i = 0; i < 6; i++)
         taps_in[i] = longint'(frame_win[i]);
      taps_in[6] = longint'(d.sample);
      taps_in[7] = 0;
      taps_in[8] = 0;
      taps_in[9] = 0;
      if (d.frame_end) begin
         // flush: centres from the oldest pending output up to the new sample
         first_c = (frame_pos >= 3'd3) ? 3 : 6 - int'(frame_pos);
         if (frame_pos == 3'd7)
            long_frames++;
         if (frame_pos < 3'd3)
            short_frames++;
         for (int c = first_c; c <= 6; c++)
            smoothed_due.push_back({sg_point(c), c == 6});
         for (int i = 0; i < 6; i++)
            frame_win[i] = '0;
         frame_pos = '0;
         frames_in++;
      end else begin
         if (frame_pos >= 3'd3)
            smoothed_due.push_back({sg_point(3), 1'b0});
         for (int i = 0; i < 6; i++)
            frame_win[i] = sample_type'(taps_in[i + 1]);
         if (frame_pos != 3'd7)
            frame_pos = frame_pos + 3'd1;
      end
   endtask

   function automatic stim_row_type mk_row(input sample_type s, input bit e, input bit typed,
                                           input sample_type ws, input bit wl);
      stim_row_type r;
      r.beat  = {s, e};
      r.typed = typed;
      r.want  = {ws, wl};
      return r;
   endfunction

   // Random sample: extremes and small values get extra weight.
   function automatic sample_type pick_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         0:       s = SAMPLE_MAX;
         1:       s = SAMPLE_MIN;
         2:       s = sample_type'($urandom_range(0, 511)) - sample_type'(256);
         default: s = sample_type'($urandom);
      endcase
      return s;
   endfunction

   // Offer one beat, hold it until taken, then predict. A typed row
   // replaces the predicted value with the hand-worked one.
   task automatic push_beat(input sgs_req_type d, input bit typed, input sgs_rsp_type want);
      if (!calm && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      beats_in++;
      sg_predict(d);
      if (typed)
         smoothed_due[smoothed_due.size() - 1] = want;
   endtask

   // Sender stops offering, then waits for every expected result.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (smoothed_due.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side: check each taken beat against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (smoothed_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, smoothed %0d frame_last %0b",
                     $time, rsp_data.smoothed, rsp_data.frame_last);
         end else begin
            due_head = smoothed_due.pop_front();
            if (rsp_data.smoothed !== due_head.smoothed) begin
               errors++;
               $display("%0t: smoothed expected %0d actual %0d",
                        $time, due_head.smoothed, rsp_data.smoothed);
            end
            if (rsp_data.frame_last !== due_head.frame_last) begin
               errors++;
               $display("%0t: frame_last expected %0b actual %0b",
                        $time, due_head.frame_last, rsp_data.frame_last);
            end
         end
      end
   end

   // Receiver: short random stalls, plus one long hold-off so the pipe and
   // skid fill and req_ready has to drop while the sender keeps offering.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!long_hold_done && beats_out >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int left;
      int len;
      bit paused_mid;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      errors = 0; beats_in = 0; beats_out = 0; frames_in = 0;
      long_frames = 0; short_frames = 0; saturated = 0;
      calm = 1'b0; long_hold_done = 1'b0; paused_mid = 1'b0;
      for (int i = 0; i < 6; i++)
         frame_win[i] = '0;
      frame_pos = '0;

      // One-sample frames: only the centre tap (7/21) sees the sample.
      directed_rows[0]  = mk_row('0,         1'b1, 1'b1, '0,                1'b1);
      directed_rows[1]  = mk_row(SAMPLE_MAX, 1'b1, 1'b1, 24'sd2796202,      1'b1);
      directed_rows[2]  = mk_row(SAMPLE_MIN, 1'b1, 1'b1, -24'sd2796202,     1'b1);
      // short frame of two, flushed by its end mark
      directed_rows[3]  = mk_row(24'sd123456,   1'b0, 1'b0, '0, 1'b0);
      directed_rows[4]  = mk_row(-24'sd654321,  1'b1, 1'b0, '0, 1'b0);
      // four-sample frame: end mark releases the full four results
      directed_rows[5]  = mk_row(24'sd1000,     1'b0, 1'b0, '0, 1'b0);
      directed_rows[6]  = mk_row(-24'sd2000,    1'b0, 1'b0, '0, 1'b0);
      directed_rows[7]  = mk_row(24'sd3000000,  1'b0, 1'b0, '0, 1'b0);
      directed_rows[8]  = mk_row(-24'sd4000000, 1'b1, 1'b0, '0, 1'b0);
      // edges at min, core at max: first centre result clamps high
      directed_rows[9]  = mk_row(SAMPLE_MIN, 1'b0, 1'b0, '0, 1'b0);
      for (int i = 10; i < 15; i++)
         directed_rows[i] = mk_row(SAMPLE_MAX, 1'b0, 1'b0, '0, 1'b0);
      directed_rows[15] = mk_row(SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MAX, 1'b0);
      directed_rows[16] = mk_row('0,         1'b1, 1'b0, '0, 1'b0);
      // mirror image: clamps low
      directed_rows[17] = mk_row(SAMPLE_MAX, 1'b0, 1'b0, '0, 1'b0);
      for (int i = 18; i < 23; i++)
         directed_rows[i] = mk_row(SAMPLE_MIN, 1'b0, 1'b0, '0, 1'b0);
      directed_rows[23] = mk_row(SAMPLE_MAX, 1'b0, 1'b1, SAMPLE_MIN, 1'b0);
      directed_rows[24] = mk_row('0,         1'b1, 1'b0, '0, 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         push_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

      // sender pause: let every directed result come home first
      wait_drained();

      // Random frames: mostly short, one in eight long enough to saturate
      // the position count. Last frame is cut to fit and always closed.
      left = RANDOM_BEATS;
      while (left > 0) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 9);
         if (len > left)
            len = left;
         for (int k = 0; k < len; k++) begin
            calm = (left <= CALM_BEATS);
            push_beat({pick_sample(), k == len - 1}, 1'b0, '0);
            left--;
            if (!paused_mid && left == PAUSE_AT) begin
               paused_mid = 1'b1;
               wait_drained();
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d beats in %0d frames (%0d short, %0d past the position limit).",
               beats_in, frames_in, short_frames, long_frames);
      $display("Checked %0d smoothed beats, %0d of them predicted to clamp.",
               beats_out, saturated);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/sgs_pkg.sv
src/sgs_cell.sv
src/sgs_div21.sv
src/savitzky_golay_smoothing.sv
verif/testbench.sv
